@@ rtl/gnnt_pkg.sv @@
`timescale 1ns / 1ps
// gnnt_pkg: shared types and constants of the gated nearest-neighbor tracker.
// No dependencies; used by the interfaces, the cell and the top level.
package gnnt_pkg;

  localparam int CoordW    = 16;
  localparam int TrackIdW  = 10;
  localparam int EntryIdxW = 6;
  localparam int DistW     = 33;
  localparam int SqW       = 32;
  localparam int CfgIdxW   = 1;

  localparam logic [DistW-1:0] MaxDistReset = 33'd8589672450;

  localparam logic [CfgIdxW-1:0] CfgMinDist = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxDist = 1'b1;

  typedef enum logic [1:0] {
    ModeAppend = 2'd0,
    ModeQuery  = 2'd1,
    ModeRead   = 2'd2,
    ModeClear  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFinish
  } state_e;

  typedef struct packed {
    mode_e                       mode;
    logic signed [CoordW-1:0]    pos_x;
    logic signed [CoordW-1:0]    pos_y;
    logic [TrackIdW-1:0]         track_id;
    logic [EntryIdxW-1:0]        entry_index;
  } in_beat_t;

  typedef struct packed {
    logic                  found;
    logic [EntryIdxW-1:0]  match_index;
    logic                  newly_assigned;
    logic                  point_has_id;
    logic [TrackIdW-1:0]   point_track_id;
    logic [DistW-1:0]      dist_sq;
  } out_beat_t;

  // Token that walks the cell row: best match so far plus read-back data.
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [DistW-1:0]     best_d;
    logic                 best_asg;
    logic                 rd_asg;
    logic [TrackIdW-1:0]  rd_id;
    logic [DistW-1:0]     rd_dist;
  } trail_t;

  // Broadcast from the controller to every cell (one selected by index).
  typedef struct packed {
    logic                     app_en;
    logic                     clr_en;
    logic                     cmt_en;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [TrackIdW-1:0]      tid;
    logic [DistW-1:0]         sq_dist;
  } bcast_t;

endpackage

@@ rtl/gnnt_if.sv @@
`timescale 1ns / 1ps
// gnnt_in_if / gnnt_out_if: valid/ready channels of the tracker.
// Depends on gnnt_pkg for the beat types.
interface gnnt_in_if
  import gnnt_pkg::*;
();
  logic     valid;
  logic     ready;
  in_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface gnnt_out_if
  import gnnt_pkg::*;
();
  logic      valid;
  logic      ready;
  out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/gnnt_cell.sv @@
`timescale 1ns / 1ps
// gnnt_cell: one stored point; squares its offset to the query and updates
// the passing token. Depends on gnnt_pkg.
module gnnt_cell
  import gnnt_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7,
  parameter int ID_W  = 10
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [CoordW-1:0] qx_i,
  input  logic signed [CoordW-1:0] qy_i,
  input  logic [EntryIdxW-1:0]     qe_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [DistW-1:0]         min_i,
  input  logic [DistW-1:0]         max_i,
  input  bcast_t                   bcast_i,
  input  logic [IDX_W-1:0]         sel_idx_i,
  input  trail_t                   trail_i,
  input  logic [IDX_W-1:0]         trail_idx_i,
  output trail_t                   trail_o,
  output logic [IDX_W-1:0]         trail_idx_o
);

  localparam int CmpW = IDX_W + EntryIdxW;
  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(IDX);
  localparam logic [CmpW-1:0]  MyCmp = CmpW'(IDX);

  logic signed [CoordW-1:0] x_q, y_q;
  logic [ID_W-1:0]          id_q;
  logic [DistW-1:0]         dist_q;
  logic                     asg_q;
  logic [SqW-1:0]           sqx_q, sqy_q, sqx_d, sqy_d;
  trail_t                   trail_q, trail_d;
  logic [IDX_W-1:0]         tidx_q, tidx_d;

  logic signed [CoordW:0]     dx, dy;
  logic signed [2*CoordW+1:0] dx_sq, dy_sq;
  logic [DistW-1:0]           dsum;
  logic                       sel, occ, in_gate, take, rd_here;

  assign sel = (sel_idx_i == MyIdx);

  always_comb begin
    dx    = {qx_i[CoordW-1], qx_i} - {x_q[CoordW-1], x_q};
    dy    = {qy_i[CoordW-1], qy_i} - {y_q[CoordW-1], y_q};
    dx_sq = dx * dx;
    dy_sq = dy * dy;
    sqx_d = dx_sq[SqW-1:0];
    sqy_d = dy_sq[SqW-1:0];
  end

  // Squares are registered; the token meets the registered squares of the query.
  always_comb begin
    dsum    = DistW'(sqx_q) + DistW'(sqy_q);
    occ     = (MyCnt < count_i);
    in_gate = occ && (min_i < dsum) && (dsum < max_i);
    take    = in_gate && (!trail_i.hit || (dsum < trail_i.best_d));
    rd_here = (MyCmp == CmpW'(qe_i));
    trail_d = trail_i;
    tidx_d  = trail_idx_i;
    if (take) begin
      trail_d.hit      = 1'b1;
      trail_d.best_d   = dsum;
      trail_d.best_asg = asg_q;
      tidx_d           = MyIdx;
    end
    if (rd_here) begin
      trail_d.rd_asg  = asg_q;
      trail_d.rd_id   = TrackIdW'(id_q);
      trail_d.rd_dist = dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asg_q   <= 1'b0;
      trail_q <= '0;
    end else begin
      trail_q <= trail_d;
      if (bcast_i.clr_en) begin
        asg_q <= 1'b0;
      end else if (bcast_i.app_en && sel) begin
        asg_q <= 1'b0;
      end else if (bcast_i.cmt_en && sel) begin
        asg_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    tidx_q <= tidx_d;
    if (bcast_i.app_en && sel) begin
      x_q <= bcast_i.x;
      y_q <= bcast_i.y;
    end
    if (bcast_i.cmt_en && sel) begin
      id_q   <= bcast_i.tid[ID_W-1:0];
      dist_q <= bcast_i.sq_dist;
    end
  end

  assign trail_o     = trail_q;
  assign trail_idx_o = tidx_q;

endmodule

@@ rtl/gated_nearest_neighbor_tracker_core.sv @@
`timescale 1ns / 1ps
// gated_nearest_neighbor_tracker_core: top level, controller plus the cell row.
// Depends on gnnt_pkg, gnnt_in_if / gnnt_out_if and gnnt_cell.
//
//  channel  | dir | beat
//  ---------+-----+--------------------------------------------------------
//  in_i     | in  | mode, pos_x, pos_y, track_id, entry_index
//  out_o    | out | found, match_index, newly_assigned, point_has_id,
//           |     | point_track_id, dist_sq (modes query and read only)
//  cfg_*    | in  | write port: index 0 min_dist_sq, index 1 max_dist_sq
//
// Append and clear complete at acceptance; in_i.ready stays high, so they can follow back to back.
// Query and read pass through squaring (registered), one token hop per cell,
// a latch of the row's exit and formatting into the output register; the token
// walks the row one cell per cycle, and the next item is taken only after the
// result is in the output register.
// A finished beat waits in the output register; the next item is taken while
// it waits, and a new result only stalls if that register is still full.
// Reset (rst_ni low, async) empties the table and clears every assigned flag.
module gated_nearest_neighbor_tracker_core
  import gnnt_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int ID_BITS    = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DistW-1:0]   cfg_data_i,
  gnnt_in_if.sink            in_i,
  gnnt_out_if.source         out_o
);

  localparam int IdxW     = $clog2(MAX_POINTS);
  localparam int CntW     = $clog2(MAX_POINTS + 1);
  localparam int StoreIdW = (ID_BITS < TrackIdW) ? ID_BITS : TrackIdW;
  localparam int IdxExtW  = IdxW + EntryIdxW;
  localparam int CntExtW  = CntW + EntryIdxW;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_POINTS);

  // Gate limits
  logic [DistW-1:0] min_q, max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '0;
      max_q <= MaxDistReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMinDist: min_q <= cfg_data_i;
        CfgMaxDist: max_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Controller state
  state_e                   state_q, state_d;
  mode_e                    mode_q;
  logic signed [CoordW-1:0] qx_q, qy_q;
  logic [EntryIdxW-1:0]     qe_q;
  logic [TrackIdW-1:0]      tid_q;
  logic [CntW-1:0]          count_q;
  logic                     start_q, launch_q;
  trail_t                   res_q;
  logic [IdxW-1:0]          res_idx_q;
  out_beat_t                out_q, out_d;
  logic                     out_valid_q;

  logic   accept, full, out_free, finish_fire, scan_done, is_scan_op;
  bcast_t bcast;
  logic [IdxW-1:0] sel_idx;

  // Token chain: slot k feeds cell k, slot MAX_POINTS is the row's exit.
  trail_t          trail_w [MAX_POINTS+1];
  logic [IdxW-1:0] tidx_w  [MAX_POINTS+1];

  assign in_i.ready  = (state_q == StIdle);
  assign accept      = in_i.valid && in_i.ready;
  assign full        = (count_q == CntMax);
  assign out_free    = !out_valid_q || out_o.ready;
  assign scan_done   = trail_w[MAX_POINTS].valid;
  assign finish_fire = (state_q == StFinish) && out_free;
  assign is_scan_op  = (in_i.payload.mode == ModeQuery) || (in_i.payload.mode == ModeRead);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (accept && is_scan_op) state_d = StScan;
      StScan:   if (scan_done) state_d = StFinish;
      StFinish: if (out_free) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Broadcast: append and clear at acceptance, commit when the result is latched into the output register.
  always_comb begin
    bcast   = '0;
    sel_idx = res_idx_q;
    if (accept && (in_i.payload.mode == ModeAppend) && !full) begin
      bcast.app_en = 1'b1;
      bcast.x      = in_i.payload.pos_x;
      bcast.y      = in_i.payload.pos_y;
      sel_idx      = count_q[IdxW-1:0];
    end
    if (accept && (in_i.payload.mode == ModeClear)) begin
      bcast.clr_en = 1'b1;
    end
    if (finish_fire && (mode_q == ModeQuery) && res_q.hit && !res_q.best_asg) begin
      bcast.cmt_en  = 1'b1;
      bcast.tid     = tid_q;
      bcast.sq_dist = res_q.best_d;
    end
  end

  // Result formatting
  logic [IdxExtW-1:0] best_ext;
  logic               rd_found, rd_has;

  always_comb begin
    best_ext = IdxExtW'(res_idx_q);
    rd_found = (CntExtW'(qe_q) < CntExtW'(count_q));
    rd_has   = rd_found && res_q.rd_asg;
    out_d    = '0;
    if (mode_q == ModeRead) begin
      out_d.found          = rd_found;
      out_d.match_index    = qe_q;
      out_d.point_has_id   = rd_has;
      out_d.point_track_id = rd_has ? res_q.rd_id : '0;
      out_d.dist_sq        = rd_has ? res_q.rd_dist : '0;
    end else begin
      out_d.found          = res_q.hit;
      out_d.match_index    = res_q.hit ? best_ext[EntryIdxW-1:0] : '0;
      out_d.newly_assigned = res_q.hit && !res_q.best_asg;
      out_d.dist_sq        = res_q.hit ? res_q.best_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      start_q     <= 1'b0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeAppend;
    end else begin
      state_q  <= state_d;
      start_q  <= accept && is_scan_op;
      launch_q <= start_q;
      if (accept) begin
        mode_q <= in_i.payload.mode;
      end
      if (bcast.app_en) begin
        count_q <= count_q + CntW'(1);
      end else if (bcast.clr_en) begin
        count_q <= '0;
      end
      if (finish_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept && is_scan_op) begin
      qx_q  <= in_i.payload.pos_x;
      qy_q  <= in_i.payload.pos_y;
      qe_q  <= in_i.payload.entry_index;
      tid_q <= in_i.payload.track_id;
    end
    if (scan_done) begin
      res_q     <= trail_w[MAX_POINTS];
      res_idx_q <= tidx_w[MAX_POINTS];
    end
    if (finish_fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Fresh token enters cell 0 once the squares of the row are registered.
  always_comb begin
    trail_w[0]       = '0;
    trail_w[0].valid = launch_q;
    tidx_w[0]        = '0;
  end

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    gnnt_cell #(
      .IDX   (k),
      .IDX_W (IdxW),
      .CNT_W (CntW),
      .ID_W  (StoreIdW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .qx_i        (qx_q),
      .qy_i        (qy_q),
      .qe_i        (qe_q),
      .count_i     (count_q),
      .min_i       (min_q),
      .max_i       (max_q),
      .bcast_i     (bcast),
      .sel_idx_i   (sel_idx),
      .trail_i     (trail_w[k]),
      .trail_idx_i (tidx_w[k]),
      .trail_o     (trail_w[k+1]),
      .trail_idx_o (tidx_w[k+1])
    );
  end

endmodule

@@ dv/gated_nearest_neighbor_tracker_core_tb.sv @@
`timescale 1ns / 1ps
// gated_nearest_neighbor_tracker_core_tb: self-checking bench for the tracker core.
// Drives the in_i / out_o channels and the gate registers, and predicts every result beat.
// Depends on gnnt_pkg, gnnt_in_if / gnnt_out_if and the core RTL.
module gated_nearest_neighbor_tracker_core_tb;
  import gnnt_pkg::*;

  localparam int MaxPts       = 64;
  localparam int IdBits       = 10;
  // A query walks the whole cell row; SettleCycles covers that walk plus slack.
  localparam int SettleCycles = MaxPts + 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Block inputs start known; the always blocks and the sequence drive them.
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = CfgMinDist;
  logic [DistW-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  in_beat_t            in_beat  = '0;
  logic                out_ready = 1'b0;

  gnnt_in_if  in_if ();
  gnnt_out_if out_if ();

  assign in_if.valid   = in_valid;
  assign in_if.payload = in_beat;
  assign out_if.ready  = out_ready;

  gated_nearest_neighbor_tracker_core #(
    .MAX_POINTS(MaxPts),
    .ID_BITS   (IdBits)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Shadow of the point table and the gate.
  logic signed [CoordW-1:0] frame_x   [MaxPts];
  logic signed [CoordW-1:0] frame_y   [MaxPts];
  logic [TrackIdW-1:0]      frame_id  [MaxPts];
  logic                     frame_own [MaxPts];
  logic [DistW-1:0]         frame_dist[MaxPts];
  int unsigned              frame_cnt;
  logic [DistW-1:0]         gate_lo;
  logic [DistW-1:0]         gate_hi;

  in_beat_t  frames_q[$];   // beats waiting to be driven
  out_beat_t tracks_due[$]; // predicted result beats, oldest first

  int beats_queued = 0;
  int beats_taken  = 0;
  int frames_made  = 0;     // beats queued that the block does not ignore
  int gen_cnt      = 0;     // table fill as seen by the stimulus generator
  int mismatches   = 0;

  int in_gap   = 0;
  int in_calm  = 0;
  int out_stall = 0;
  int out_calm = 0;

  function automatic logic [DistW-1:0] sq_gap(logic signed [CoordW-1:0] ax, ay, bx, by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    return DistW'(dx * dx + dy * dy);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Apply one accepted beat to the shadow table; queue its result if it has one.
  task automatic associate_beat(input in_beat_t b);
    out_beat_t        r;
    logic             hit;
    int               best;
    logic [DistW-1:0] best_d;
    logic [DistW-1:0] d;
    r = '0;
    case (b.mode)
      ModeAppend: begin
        // full table: beat is dropped
        if (frame_cnt < MaxPts) begin
          frame_x[frame_cnt]    = b.pos_x;
          frame_y[frame_cnt]    = b.pos_y;
          frame_id[frame_cnt]   = '0;
          frame_own[frame_cnt]  = 1'b0;
          frame_dist[frame_cnt] = '0;
          frame_cnt++;
        end
      end
      ModeClear: begin
        frame_cnt = 0;
        foreach (frame_own[j]) frame_own[j] = 1'b0;
      end
      ModeQuery: begin
        hit    = 1'b0;
        best   = 0;
        best_d = '0;
        // strict gate on both sides; first index wins a tie
        for (int j = 0; j < frame_cnt; j++) begin
          d = sq_gap(b.pos_x, b.pos_y, frame_x[j], frame_y[j]);
          if (gate_lo < d && d < gate_hi && (!hit || d < best_d)) begin
            hit    = 1'b1;
            best   = j;
            best_d = d;
          end
        end
        if (hit) begin
          r.found       = 1'b1;
          r.match_index = EntryIdxW'(best);
          r.dist_sq     = best_d;
          if (!frame_own[best]) begin
            frame_own[best]  = 1'b1;
            frame_id[best]   = b.track_id;
            frame_dist[best] = best_d;
            r.newly_assigned = 1'b1;
          end
        end
        tracks_due.push_back(r);
      end
      default: begin
        r.match_index = b.entry_index;
        if (b.entry_index < frame_cnt) begin
          r.found = 1'b1;
          if (frame_own[b.entry_index]) begin
            r.point_has_id   = 1'b1;
            r.point_track_id = frame_id[b.entry_index];
            r.dist_sq        = frame_dist[b.entry_index];
          end
        end
        tracks_due.push_back(r);
      end
    endcase
  endtask

  task automatic log_mismatch(input string what, input logic [DistW-1:0] got,
                              input logic [DistW-1:0] want);
    mismatches++;
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic check_track(input out_beat_t got);
    out_beat_t want;
    if (tracks_due.size() == 0) begin
      log_mismatch("result beat with nothing due", 1, 0);
      return;
    end
    want = tracks_due.pop_front();
    if (got.found !== want.found) log_mismatch("found", got.found, want.found);
    if (got.match_index !== want.match_index)
      log_mismatch("match_index", got.match_index, want.match_index);
    if (got.newly_assigned !== want.newly_assigned)
      log_mismatch("newly_assigned", got.newly_assigned, want.newly_assigned);
    if (got.point_has_id !== want.point_has_id)
      log_mismatch("point_has_id", got.point_has_id, want.point_has_id);
    if (got.point_track_id !== want.point_track_id)
      log_mismatch("point_track_id", got.point_track_id, want.point_track_id);
    if (got.dist_sq !== want.dist_sq) log_mismatch("dist_sq", got.dist_sq, want.dist_sq);
  endtask

  // Input driver: holds a beat until it is taken, then idles a random gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
    end else begin
      if (in_valid && in_if.ready) begin
        associate_beat(in_beat);
        beats_taken++;
      end
      if (in_calm > 0) in_calm--;
      else if ($urandom_range(0, 299) == 0) in_calm = $urandom_range(100, 400);
      if (!in_valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (frames_q.size() != 0) begin
          in_beat  <= frames_q.pop_front();
          in_valid <= 1'b1;
          in_gap   = (in_calm > 0) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each taken beat and stalls ready at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ready && out_if.valid) check_track(out_if.payload);
      if (out_calm > 0) out_calm--;
      else if ($urandom_range(0, 299) == 0) out_calm = $urandom_range(100, 400);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else if (out_calm == 0 && $urandom_range(0, 7) == 0) begin
        out_stall = idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input mode_e m, input int x, input int y, input int tid,
                           input int idx);
    in_beat_t b;
    bit       dropped;
    dropped       = 1'b0;
    b.mode        = m;
    b.pos_x       = 16'(x);
    b.pos_y       = 16'(y);
    b.track_id    = TrackIdW'(tid);
    b.entry_index = EntryIdxW'(idx);
    if (m == ModeAppend) begin
      if (gen_cnt == MaxPts) dropped = 1'b1;
      else gen_cnt++;
    end else if (m == ModeClear) begin
      gen_cnt = 0;
    end
    if (!dropped) frames_made++;
    frames_q.push_back(b);
    beats_queued++;
  endtask

  // Random frames: mostly a cluster of points followed by queries near it and
  // some read-backs; the rest is raw noise on every field.
  task automatic queue_frames(input int n);
    int stop_at, cx, cy, spread, npts, r;
    stop_at = frames_made + n;
    while (frames_made < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        if (gen_cnt > 48 || $urandom_range(0, 2) == 0)
          push_item(ModeClear, $urandom, $urandom, $urandom, $urandom);
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        case ($urandom_range(0, 4))
          0:       spread = 1;
          1:       spread = 4;
          2:       spread = 40;
          3:       spread = 600;
          default: spread = 32767;
        endcase
        r = $urandom_range(0, 9);
        if (r < 7)      npts = $urandom_range(1, 12);
        else if (r < 9) npts = $urandom_range(13, 40);
        else            npts = MaxPts - gen_cnt + $urandom_range(1, 3); // run past full
        repeat (npts)
          push_item(ModeAppend, cx + $urandom_range(0, 2 * spread) - spread,
                    cy + $urandom_range(0, 2 * spread) - spread, $urandom, $urandom);
        repeat ($urandom_range(1, 8))
          push_item(ModeQuery, cx + $urandom_range(0, 2 * spread) - spread,
                    cy + $urandom_range(0, 2 * spread) - spread, $urandom, $urandom);
        repeat ($urandom_range(0, 4))
          push_item(ModeRead, $urandom, $urandom, $urandom,
                    (gen_cnt == 0 || $urandom_range(0, 4) == 0) ?
                    $urandom_range(0, 63) : $urandom_range(0, gen_cnt - 1));
      end else begin
        push_item(mode_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Wait until every beat is taken and every result is back, then let any
  // append or clear still in flight drain.
  task automatic settle();
    while (beats_taken != beats_queued || tracks_due.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_gate(input logic [DistW-1:0] lo, input logic [DistW-1:0] hi);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgMinDist;
    cfg_data <= lo;
    @(posedge clk_i);
    cfg_idx  <= CfgMaxDist;
    cfg_data <= hi;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    gate_lo = lo;
    gate_hi = hi;
  endtask

  initial begin : run_seq
    logic [DistW-1:0] lo;
    logic [DistW-1:0] hi;
    gate_lo   = '0;
    gate_hi   = MaxDistReset;
    frame_cnt = 0;
    foreach (frame_own[j]) frame_own[j] = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset gate.
    push_item(ModeQuery, 100, -100, 7, 0);           // empty table
    push_item(ModeRead, 0, 0, 0, 0);                 // read past the end
    push_item(ModeRead, 0, 0, 0, 63);
    push_item(ModeAppend, -32768, -32768, 0, 0);
    push_item(ModeAppend, 32767, 32767, 1023, 63);
    push_item(ModeAppend, 0, 0, 0, 0);
    push_item(ModeAppend, 0, 0, 0, 0);               // duplicate: tie on distance
    push_item(ModeAppend, 3, 4, 0, 0);
    // zero distance is outside the gate; full span sits on the upper limit
    push_item(ModeQuery, 32767, 32767, 1023, 0);
    push_item(ModeQuery, 1, 0, 0, 0);                // tie, lowest index takes it
    push_item(ModeQuery, 0, 1, 512, 0);              // same point, already owned
    push_item(ModeQuery, -32768, 32767, 341, 0);
    push_item(ModeQuery, 32767, -32768, 682, 0);
    push_item(ModeQuery, -32768, -32768, 1, 0);
    for (int i = 0; i < 6; i++) push_item(ModeRead, 0, 0, 0, i);
    push_item(ModeClear, 0, 0, 0, 0);
    push_item(ModeRead, 0, 0, 0, 2);                 // gone after clear
    push_item(ModeQuery, 0, 0, 9, 0);
    push_item(ModeAppend, 1, 1, 0, 0);
    push_item(ModeRead, 0, 0, 0, 0);                 // flag cleared, reads unassigned

    // Random phases, each under its own gate.
    for (int p = 0; p < 9; p++) begin
      settle();
      case (p)
        0: begin lo = '0;            hi = MaxDistReset; end
        1: begin lo = '0;            hi = 33'd5000;     end
        2: begin lo = 33'd20;        hi = 33'd3000;     end
        3: begin lo = '0;            hi = 33'd2;        end // only distance one fits
        4: begin lo = 33'd1000;      hi = 33'd1000;     end // empty gate
        5: begin lo = MaxDistReset;  hi = '0;           end // inverted
        6: begin
          lo = DistW'($urandom_range(0, 1000));
          hi = lo + {1'b0, $urandom};
        end
        7: begin
          lo = {1'b0, $urandom};
          hi = {1'b1, $urandom_range(0, 32'hFFFC_0002)};
        end
        default: begin lo = 33'd4; hi = 33'd100000; end
      endcase
      set_gate(lo, hi);
      queue_frames(100);
    end
    settle();

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
